// File: sv/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the coherent cache tag store: operation
// codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package cts_pkg;

    // operation codes carried in tuser
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PROBE  = 3'd0,
        OP_LOAD   = 3'd1,
        OP_STORE  = 3'd2,
        OP_UPDATE = 3'd3,
        OP_INVAL  = 3'd4
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // block offset register
    localparam int          CFG_W         = 5;
    localparam logic [4:0]  CFG_OFF_RESET = 5'd6;

    // flag count per line and their order in the update field group
    localparam int FLAG_CNT  = 4;
    localparam int NF_MOD    = 0;
    localparam int NF_EXCL   = 1;
    localparam int NF_SHARED = 2;
    localparam int NF_VALID  = 3;

    // result tdata: was_present, was_modified, was_exclusive, zero fill
    localparam int OUT_DATA_W = 8;

endpackage

// File: sv/coherent_cache_tag_store.sv
// ----------------------------------------------------------------------------
// coherent_cache_tag_store
// Set-associative tag store with valid/modified/shared/exclusive flags per
// line and LRU ages, one set row per memory word, read-modify-write.
// ----------------------------------------------------------------------------
// Result: the set row is read into a register at accept, and the result is
//   registered when the lookup commits, which waits only while the previous
//   result still waits in the output register. A new transaction is taken only
//   after the memory read has been followed by the write-back of the same row.
// Reset: block offset returns to 6, then a clearing pass writes every set row
//   while tready stays low; config writes still land.
module coherent_cache_tag_store
    import cts_pkg::*;
#(
    parameter int SET_BITS  = 6,
    parameter int WAYS      = 4,
    parameter int ADDR_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: block_offset_bits
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // address, new_modified, new_exclusive, new_shared, new_valid, zero fill
    input  logic [((ADDR_BITS+FLAG_CNT+7)/8)*8-1:0] i_s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]        i_s_axis_tuser,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // was_present, was_modified, was_exclusive, zero fill
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W     = ADDR_BITS - SET_BITS;
    localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SHW       = $clog2(31 + SET_BITS + 1);
    localparam int V_POS     = TAG_W;
    localparam int M_POS     = TAG_W + 1;
    localparam int S_POS     = TAG_W + 2;
    localparam int E_POS     = TAG_W + 3;
    localparam int AGE_LSB   = TAG_W + FLAG_CNT;
    localparam int LINE_W    = TAG_W + FLAG_CNT + AGE_W;
    localparam int SEEN_W    = 1 << AGE_W;

    typedef logic [WAYS-1:0][LINE_W-1:0] t_row;

    // set row memory
    t_row                 mem [NUM_SETS];
    t_row                 r_rd_row;

    t_state               r_state, n_state;
    logic [SET_IDX_W-1:0] r_clr_cnt;
    logic [CFG_W-1:0]     r_block_off;
    logic [OP_W-1:0]      r_op;
    logic [TAG_W-1:0]     r_tag;
    logic [SET_IDX_W-1:0] r_set;
    logic [FLAG_CNT-1:0]  r_new_flags;
    logic                 r_out_valid;
    logic [2:0]           r_out_data;

    logic                 acc;
    logic                 commit;
    logic                 clr_we;
    logic                 mem_we;
    logic [SET_IDX_W-1:0] mem_waddr;
    t_row                 mem_wdata;
    t_row                 clr_row;
    t_row                 n_row;

    logic [ADDR_BITS-1:0] in_addr;
    logic [ADDR_BITS-1:0] sh_set;
    logic [ADDR_BITS-1:0] sh_tag;
    logic [SET_IDX_W-1:0] in_set;

    logic [WAYS-1:0]      match_vec;
    logic [WAYS-1:0]      valid_vec;
    logic [WAYS-1:0]      first_vec;
    logic [WAYS-1:0]      victim_vec;
    logic [WAYS-1:0]      sel_vec;
    logic                 hit;
    logic                 present;
    logic                 was_mod;
    logic                 was_excl;
    logic                 is_access;
    logic [AGE_W-1:0]     old_age;
    logic [SEEN_W-1:0]    age_seen;

    // field extraction at accept: set index and tag from the address
    assign in_addr = i_s_axis_tdata[ADDR_BITS-1:0];
    assign sh_set  = in_addr >> r_block_off;
    assign sh_tag  = in_addr >> (SHW'(r_block_off) + SHW'(SET_BITS));
    assign in_set  = (SET_BITS == 0) ? '0 : sh_set[SET_IDX_W-1:0];

    assign acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign commit = (r_state == ST_LOOKUP) && (!r_out_valid || i_m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == SET_IDX_W'(NUM_SETS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (commit) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        clr_we          = 1'b0;
        unique case (r_state)
            ST_CLEAR:  clr_we          = 1'b1;
            ST_IDLE:   o_s_axis_tready = 1'b1;
            ST_LOOKUP: ;
            default:   ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_block_off <= CFG_OFF_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_we) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cfg_wr_en) r_block_off <= i_cfg_wr_data;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op        <= i_s_axis_tuser;
            r_tag       <= sh_tag[TAG_W-1:0];
            r_set       <= in_set;
            r_new_flags <= i_s_axis_tdata[ADDR_BITS +: FLAG_CNT];
        end
        if (commit) r_out_data <= {was_excl, was_mod, present};
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 3){1'b0}}, r_out_data};

    // reset row: zero tags and flags, ages in way order
    always_comb begin
        clr_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            clr_row[w][AGE_LSB +: AGE_W] = AGE_W'(w);
        end
    end

    // memory: one write port, one registered read port
    assign mem_we    = clr_we || commit;
    assign mem_waddr = clr_we ? r_clr_cnt : r_set;
    assign mem_wdata = clr_we ? clr_row : n_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (acc) r_rd_row <= mem[in_set];
    end

    // tag compare and per-way status
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match_vec[w] = (r_rd_row[w][TAG_W-1:0] == r_tag);
            valid_vec[w] = r_rd_row[w][V_POS];
        end
    end

    // first matching way and replacement victim
    always_comb begin
        logic found;
        logic inv_found;
        found      = 1'b0;
        inv_found  = 1'b0;
        first_vec  = '0;
        victim_vec = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (match_vec[w] && !found) begin
                first_vec[w] = 1'b1;
                found        = 1'b1;
            end
            if (!valid_vec[w] && !inv_found) begin
                victim_vec[w] = 1'b1;
                inv_found     = 1'b1;
            end
        end
        if (!inv_found) begin
            for (int w = 0; w < WAYS; w++) begin
                victim_vec[w] = (r_rd_row[w][AGE_LSB +: AGE_W] == AGE_W'(WAYS - 1));
            end
        end
    end

    assign hit       = |match_vec;
    assign present   = |(match_vec & valid_vec);
    assign is_access = (r_op == OP_LOAD) || (r_op == OP_STORE);
    assign sel_vec   = hit ? first_vec : victim_vec;

    // status before the operation, and the age of the touched way
    always_comb begin
        was_mod  = 1'b0;
        was_excl = 1'b0;
        old_age  = '0;
        for (int w = 0; w < WAYS; w++) begin
            was_mod  = was_mod  | (first_vec[w] & r_rd_row[w][M_POS]);
            was_excl = was_excl | (first_vec[w] & r_rd_row[w][E_POS]);
            old_age  = old_age  | (sel_vec[w] ? r_rd_row[w][AGE_LSB +: AGE_W] : '0);
        end
    end

    // modified row written back
    always_comb begin
        n_row = r_rd_row;
        for (int w = 0; w < WAYS; w++) begin
            case (r_op)
                OP_LOAD, OP_STORE: begin
                    if (r_rd_row[w][AGE_LSB +: AGE_W] < old_age) begin
                        n_row[w][AGE_LSB +: AGE_W] = r_rd_row[w][AGE_LSB +: AGE_W] + 1'b1;
                    end
                    if (sel_vec[w]) begin
                        n_row[w][AGE_LSB +: AGE_W] = '0;
                        if (!hit) begin
                            // fill on miss
                            n_row[w][TAG_W-1:0] = r_tag;
                            n_row[w][V_POS]     = 1'b1;
                            n_row[w][E_POS]     = 1'b0;
                            n_row[w][S_POS]     = (r_op == OP_LOAD);
                            n_row[w][M_POS]     = (r_op == OP_STORE);
                        end else if (r_op == OP_STORE) begin
                            n_row[w][M_POS] = 1'b1;
                            n_row[w][V_POS] = 1'b1;
                            n_row[w][S_POS] = 1'b0;
                        end else if (!valid_vec[w]) begin
                            // load revalidates an invalid line as shared
                            n_row[w][V_POS] = 1'b1;
                            n_row[w][S_POS] = 1'b1;
                            n_row[w][M_POS] = 1'b0;
                        end
                    end
                end
                OP_UPDATE: begin
                    if (first_vec[w]) begin
                        n_row[w][M_POS] = r_new_flags[NF_MOD];
                        n_row[w][E_POS] = r_new_flags[NF_EXCL];
                        n_row[w][S_POS] = r_new_flags[NF_SHARED];
                        n_row[w][V_POS] = r_new_flags[NF_VALID];
                    end
                end
                OP_INVAL: begin
                    if (match_vec[w]) n_row[w][V_POS] = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // ages present in the row being written
    always_comb begin
        age_seen = '0;
        for (int w = 0; w < WAYS; w++) begin
            age_seen[n_row[w][AGE_LSB +: AGE_W]] = 1'b1;
        end
    end

    // checks
    ap_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state == ST_LOOKUP))
        else $error("accepted transaction did not enter lookup");

    ap_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_m_axis_tvalid)
        else $error("committed lookup produced no result");

    ap_ages_permutation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> ($countones(age_seen) == WAYS))
        else $error("written set ages are not a permutation");

    ap_single_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && is_access && !hit) |-> $onehot(victim_vec))
        else $error("miss did not select exactly one victim way");

    ap_first_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) |-> $onehot0(first_vec))
        else $error("more than one first matching way");

endmodule

// File: tb/coherent_cache_tag_store_test.sv
// ----------------------------------------------------------------------------
// coherent_cache_tag_store_test
// Self-checking bench for the coherent cache tag store. Requests are streamed
// from a queue, and each accepted request runs through a behavioral tag/flag/
// LRU model that queues the expected lookup result. Results are checked field
// by field in order. The block offset register is swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module coherent_cache_tag_store_test;
    import cts_pkg::*;

    localparam int SET_BITS  = 6;
    localparam int WAYS      = 4;
    localparam int ADDR_BITS = 48;
    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int NUM_LINES = NUM_SETS * WAYS;
    localparam int IN_DATA_W = ((ADDR_BITS + FLAG_CNT + 7) / 8) * 8;

    localparam int IDLE_PCT      = 19;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    // opcodes beyond the defined set, treated as probe
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [ADDR_BITS-1:0] addr;
        logic [FLAG_CNT-1:0]  nf;
    } t_req;

    typedef struct packed {
        logic present;
        logic modified;
        logic exclusive;
    } t_lookup;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [OP_W-1:0]       i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // stimulus and scoreboard state
    t_req    req_pending_q[$];
    t_lookup lookup_expect_q[$];
    logic    req_taken = 1'b0;
    bit      no_idle = 1'b0;
    bit      hold_req = 1'b0;
    bit      hold_used = 1'b0;
    int      hold_left = 0;
    int      err_cnt = 0;
    int      stall_cnt = 0;

    // model of the tag store
    logic [ADDR_BITS-1:0] tag_mem[NUM_LINES];
    logic                 valid_mem[NUM_LINES];
    logic                 mod_mem[NUM_LINES];
    logic                 shared_mem[NUM_LINES];
    logic                 excl_mem[NUM_LINES];
    int                   age_mem[NUM_LINES];
    int                   blk_off;

    coherent_cache_tag_store #(
        .SET_BITS  (SET_BITS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // lookup result as seen before the operation, then state update
    function automatic t_lookup predict_lookup(input t_req r);
        logic [63:0] a;
        logic [63:0] tg;
        int          base;
        int          hit_way;
        int          v;
        int          old_age;
        int          best;
        bit          hit;
        bit          present;
        t_lookup     res;
        a       = 64'(r.addr);
        base    = int'((a >> blk_off) & 64'(NUM_SETS - 1)) * WAYS;
        tg      = a >> (blk_off + SET_BITS);
        hit     = 1'b0;
        present = 1'b0;
        hit_way = 0;
        for (int i = 0; i < WAYS; i++) begin
            if (64'(tag_mem[base+i]) == tg) begin
                if (!hit) begin
                    hit     = 1'b1;
                    hit_way = i;
                end
                if (valid_mem[base+i])
                    present = 1'b1;
            end
        end
        res.present   = present;
        res.modified  = hit ? mod_mem[base+hit_way] : 1'b0;
        res.exclusive = hit ? excl_mem[base+hit_way] : 1'b0;

        if (r.op == OP_LOAD || r.op == OP_STORE) begin
            if (hit) begin
                v = hit_way;
                if (r.op == OP_LOAD) begin
                    // load revalidates an invalid line as shared
                    if (!valid_mem[base+v]) begin
                        valid_mem[base+v]  = 1'b1;
                        shared_mem[base+v] = 1'b1;
                        mod_mem[base+v]    = 1'b0;
                    end
                end else begin
                    mod_mem[base+v]    = 1'b1;
                    valid_mem[base+v]  = 1'b1;
                    shared_mem[base+v] = 1'b0;
                end
            end else begin
                // victim: first invalid way, else the oldest
                v = -1;
                for (int i = 0; i < WAYS; i++)
                    if (v < 0 && !valid_mem[base+i])
                        v = i;
                if (v < 0) begin
                    best = -1;
                    for (int i = 0; i < WAYS; i++) begin
                        if (age_mem[base+i] > best) begin
                            best = age_mem[base+i];
                            v    = i;
                        end
                    end
                end
                tag_mem[base+v]    = tg[ADDR_BITS-1:0];
                valid_mem[base+v]  = 1'b1;
                excl_mem[base+v]   = 1'b0;
                shared_mem[base+v] = (r.op == OP_LOAD);
                mod_mem[base+v]    = (r.op == OP_STORE);
            end
            // move way to most recently used
            old_age = age_mem[base+v];
            for (int i = 0; i < WAYS; i++)
                if (age_mem[base+i] < old_age)
                    age_mem[base+i]++;
            age_mem[base+v] = 0;
        end else if (r.op == OP_UPDATE) begin
            if (hit) begin
                mod_mem[base+hit_way]    = r.nf[NF_MOD];
                excl_mem[base+hit_way]   = r.nf[NF_EXCL];
                shared_mem[base+hit_way] = r.nf[NF_SHARED];
                valid_mem[base+hit_way]  = r.nf[NF_VALID];
            end
        end else if (r.op == OP_INVAL) begin
            for (int i = 0; i < WAYS; i++)
                if (64'(tag_mem[base+i]) == tg)
                    valid_mem[base+i] = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [ADDR_BITS-1:0] make_addr(input logic [63:0] tag,
                                                       input int set_idx, input int off,
                                                       input logic [63:0] low);
        logic [63:0] a;
        a = (tag << (off + SET_BITS)) | (64'(set_idx) << off)
            | (low & ((64'd1 << off) - 64'd1));
        return a[ADDR_BITS-1:0];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        err_cnt++;
        $display("[%0t] mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    task automatic push_req(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] addr,
                            input logic [FLAG_CNT-1:0] nf);
        t_req r;
        r.op   = op;
        r.addr = addr;
        r.nf   = nf;
        req_pending_q.push_back(r);
    endtask

    // block until every request is sent and every result is back
    task automatic wait_idle();
        while (req_pending_q.size() != 0 || lookup_expect_q.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_offset(input int v);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = CFG_W'(v);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // random traffic around a small pool of tags and sets to force hits and evictions
    task automatic run_phase(input int off, input int n_items, input bit quiet, input bit hold);
        logic [63:0] tag_pool[6];
        int          set_pool[3];
        logic [63:0] tmask;
        int          pick;
        t_req        r;
        tmask       = (64'd1 << (ADDR_BITS - off - SET_BITS)) - 64'd1;
        tag_pool[0] = '0;
        tag_pool[1] = tmask;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = rand64() & tmask;
        set_pool[0] = 0;
        set_pool[1] = NUM_SETS - 1;
        set_pool[2] = $urandom_range(0, NUM_SETS - 1);
        @(posedge i_clk);
        no_idle = quiet;
        for (int k = 0; k < n_items; k++) begin
            r.nf = FLAG_CNT'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                r.op   = OP_W'($urandom_range(0, 7));
                r.addr = rand64();
            end else begin
                r.addr = make_addr(tag_pool[$urandom_range(0, 5)],
                                   set_pool[$urandom_range(0, 2)], off, rand64());
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    r.op = OP_PROBE;
                else if (pick < 45)
                    r.op = OP_LOAD;
                else if (pick < 68)
                    r.op = OP_STORE;
                else if (pick < 83)
                    r.op = OP_UPDATE;
                else if (pick < 96)
                    r.op = OP_INVAL;
                else
                    r.op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            end
            req_pending_q.push_back(r);
        end
        if (hold)
            hold_req = 1'b1;
        wait_idle();
        no_idle = 1'b0;
    endtask

    // request driver
    always @(negedge i_clk) begin : drive_req
        t_req r;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || req_taken) begin
            if (req_pending_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                r = req_pending_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= IN_DATA_W'({r.nf, r.addr});
                i_s_axis_tuser  <= r.op;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            hold_used       <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: config tracking, result check, prediction on accepted requests
    always @(posedge i_clk) begin : monitor
        t_req    r;
        t_lookup exp_r;
        if (!i_rst_n) begin
            blk_off = CFG_OFF_RESET;
            for (int i = 0; i < NUM_LINES; i++) begin
                tag_mem[i]    = '0;
                valid_mem[i]  = 1'b0;
                mod_mem[i]    = 1'b0;
                shared_mem[i] = 1'b0;
                excl_mem[i]   = 1'b0;
                age_mem[i]    = i % WAYS;
            end
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_wr_en)
                blk_off = int'(i_cfg_wr_data);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (lookup_expect_q.size() == 0) begin
                    report_mismatch("result with nothing pending", -1, int'(o_m_axis_tdata));
                end else begin
                    exp_r = lookup_expect_q.pop_front();
                    if (o_m_axis_tdata[0] !== exp_r.present)
                        report_mismatch("was_present", int'(exp_r.present),
                                        int'(o_m_axis_tdata[0]));
                    if (o_m_axis_tdata[1] !== exp_r.modified)
                        report_mismatch("was_modified", int'(exp_r.modified),
                                        int'(o_m_axis_tdata[1]));
                    if (o_m_axis_tdata[2] !== exp_r.exclusive)
                        report_mismatch("was_exclusive", int'(exp_r.exclusive),
                                        int'(o_m_axis_tdata[2]));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r.op   = i_s_axis_tuser;
                r.addr = i_s_axis_tdata[ADDR_BITS-1:0];
                r.nf   = i_s_axis_tdata[ADDR_BITS +: FLAG_CNT];
                lookup_expect_q.push_back(predict_lookup(r));
            end
            req_taken <= i_s_axis_tvalid && o_s_axis_tready;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin : main
        logic [63:0] tmax;
        int          off;
        tmax = (64'd1 << (ADDR_BITS - 6 - SET_BITS)) - 64'd1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero tags on invalid lines, hit/miss flag rules, eviction
        push_req(OP_PROBE,  '0, FLAG_CNT'($urandom));
        push_req(OP_LOAD,   '0, FLAG_CNT'($urandom));
        push_req(OP_LOAD,   '0, FLAG_CNT'($urandom));
        push_req(OP_STORE,  '0, FLAG_CNT'($urandom));
        push_req(OP_UPDATE, '0, '1);
        push_req(OP_PROBE,  '0, '0);
        push_req(OP_INVAL,  '0, '1);
        push_req(OP_PROBE,  '0, '0);
        push_req(OP_LOAD,   '1, '1);
        for (int t = 1; t <= 5; t++)
            push_req(OP_STORE, make_addr(64'(t), NUM_SETS - 1, 6, rand64()),
                     FLAG_CNT'($urandom));
        push_req(OP_LOAD,   make_addr(tmax, NUM_SETS - 1, 6, '0), '0);
        push_req(OP_UPDATE, make_addr(64'd9, NUM_SETS - 1, 6, '0), '1);
        push_req(OP_UPDATE, make_addr(64'd3, NUM_SETS - 1, 6, '0), '0);
        push_req(OP_STORE,  make_addr(64'd3, NUM_SETS - 1, 6, '0), '0);
        push_req(OP_UPDATE, make_addr(64'd2, NUM_SETS - 1, 6, '0), 4'b0110);
        for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++)
            push_req(OP_W'(c), make_addr(64'd2, NUM_SETS - 1, 6, '0), '1);
        push_req(OP_LOAD,   '1, '0);
        wait_idle();

        // offset sweep with random traffic
        write_offset(0);
        run_phase(0, 200, 1'b1, 1'b0);
        write_offset(16);
        run_phase(16, 200, 1'b0, 1'b1);
        write_offset(31);
        run_phase(31, 150, 1'b0, 1'b0);
        write_offset(3);
        run_phase(3, 200, 1'b0, 1'b0);
        off = $urandom_range(1, 15);
        write_offset(off);
        run_phase(off, 250, 1'b0, 1'b0);
        write_offset(6);
        run_phase(6, 200, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
